// ===== rtl/core/mcpd_pkg.sv =====
// Shared types, widths and constants for the slave-clock pulse driver.
package mcpd_pkg;

	localparam int TIME_W   = 34;   // epoch seconds
	localparam int MIN_W    = 29;   // epoch minutes, floor(2^34 / 60) fits
	localparam int CNT_W    = 16;   // pulse counts and tick counts
	localparam int OP_W     = 2;
	localparam int QUART_W  = TIME_W - 2;
	localparam int PROD_W   = 2 * QUART_W;

	// Wall time before this is treated as not yet valid
	localparam logic [TIME_W-1:0] VALID_FLOOR = 34'd1672531200;

	// floor(y / 15) = (y * RECIP_15) >> RECIP_SHIFT, exact for 32-bit y
	localparam logic [QUART_W-1:0] RECIP_15    = 32'h8888_8889;
	localparam int                 RECIP_SHIFT = 35;

	localparam logic [CNT_W-1:0] PULSE_WIDTH_RESET = 16'd100;
	localparam logic [CNT_W-1:0] PULSE_GAP_RESET   = 16'd100;
	localparam logic [CNT_W-1:0] PENDING_RESET     = 16'd2;
	localparam logic [CNT_W-1:0] CNT_MAX           = 16'hFFFF;

	// Configuration register indexes
	localparam logic REG_PULSE_WIDTH = 1'b0;
	localparam logic REG_PULSE_GAP   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 2'd0,
		OP_SET_TIME   = 2'd1,
		OP_ADD_PULSES = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	// Load strobes for the two stages in front of the state update
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} pipe_en_t;

endpackage

// ===== rtl/core/mcpd_cmd_if.sv =====
// Command channel: ticks, set-time and extra-pulse requests.
interface mcpd_cmd_if;
	import mcpd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        operation;
	logic [TIME_W-1:0]      now_seconds;
	logic [TIME_W-1:0]      operand_value;

	modport source (output valid, output operation, output now_seconds,
		output operand_value, input ready);
	modport sink (input valid, input operation, input now_seconds,
		input operand_value, output ready);
endinterface

// ===== rtl/core/mcpd_res_if.sv =====
// Result channel: bridge levels and queue status after each command.
interface mcpd_res_if;
	import mcpd_pkg::*;

	logic               valid;
	logic               ready;
	logic               enable_level;
	logic               bridge_a_level;
	logic               bridge_b_level;
	logic               busy_res;
	logic [CNT_W-1:0]   pulses_left;

	modport source (output valid, output enable_level, output bridge_a_level,
		output bridge_b_level, output busy_res, output pulses_left, input ready);
	modport sink (input valid, input enable_level, input bridge_a_level,
		input bridge_b_level, input busy_res, input pulses_left, output ready);
endinterface

// ===== rtl/core/minute_catchup_polarity_pulse_driver.sv =====
// Top level: slave-clock motor driver with minute catch-up and alternating polarity.
//
//  channel   role   handshake        payload
//  cmd       sink   valid / ready    operation, now_seconds, operand_value
//  res       source valid / ready    enable_level, bridge_a/b_level, busy_res, pulses_left
//  wr_*      sink   wr_en only       wr_index, wr_data (pulse width, pulse gap)
//
// One word is accepted per cycle unless a stall holds the pipe; each word passes the
// input register, divide-by-60 multiplier stage and state update to the result register.
// The 32x32 reciprocal multiply in the divider sets the stage length.
// Reset queues two pulses with polarity low; config returns to 100 ms width and gap.
// A stalled result register holds the pipe; cmd.ready follows res.ready back through it.
module minute_catchup_polarity_pulse_driver (
	input  logic                          clk,
	input  logic                          arst_n,
	mcpd_cmd_if.sink                      cmd,
	mcpd_res_if.source                    res,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [mcpd_pkg::CNT_W-1:0]    wr_data
);
	import mcpd_pkg::*;

	// Configuration
	logic [CNT_W-1:0] width_q, gap_q;

	// Pipeline control and payload
	logic              s1v_q, s2v_q, outv_q;
	logic              adv3;
	pipe_en_t          en;
	op_t               op_s1, op_s2;
	logic              ge_s1, ge_s2;
	logic [CNT_W-1:0]  cnt_s1, cnt_s2;
	logic [TIME_W-1:0] dividend;
	logic [MIN_W-1:0]  min_s2;

	// Driver state
	logic              pol_q, pol_d;
	logic [CNT_W-1:0]  pend_q, pend_d;
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  cd_q, cd_d;
	logic [MIN_W-1:0]  shown_q, shown_d;

	logic [CNT_W-1:0]  cd_dec;
	logic [MIN_W-1:0]  diff;
	logic [CNT_W:0]    sum;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= PULSE_WIDTH_RESET;
			gap_q   <= PULSE_GAP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PULSE_WIDTH: width_q <= wr_data;
				REG_PULSE_GAP:   gap_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Handshake: each stage moves when the one after it is empty or moving
	assign adv3      = s2v_q && (!outv_q || res.ready);
	assign en.ld_s2  = !s2v_q || adv3;
	assign en.ld_s1  = !s1v_q || (s1v_q && en.ld_s2);
	assign cmd.ready = en.ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1v_q  <= 1'b0;
			s2v_q  <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			if (en.ld_s1) s1v_q <= cmd.valid;
			if (en.ld_s2) s2v_q <= s1v_q;
			if (!outv_q || res.ready) outv_q <= s2v_q;
		end
	end

	// Set-time divides the operand, everything else the wall time
	assign dividend = (op_t'(cmd.operation) == OP_SET_TIME) ? cmd.operand_value
		: cmd.now_seconds;

	mcpd_div60 u_div (
		.clk        (clk),
		.en         (en),
		.seconds    (dividend),
		.minutes_s2 (min_s2)
	);

	// Side fields that travel with the quotient
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			op_s1  <= op_t'(cmd.operation);
			ge_s1  <= cmd.now_seconds >= VALID_FLOOR;
			cnt_s1 <= (|cmd.operand_value[TIME_W-1:CNT_W]) ? CNT_MAX
				: cmd.operand_value[CNT_W-1:0];
		end
		if (en.ld_s2) begin
			op_s2  <= op_s1;
			ge_s2  <= ge_s1;
			cnt_s2 <= cnt_s1;
		end
	end

	// Next state for the word leaving stage 2
	always_comb begin
		pol_d   = pol_q;
		pend_d  = pend_q;
		phase_d = phase_q;
		cd_d    = cd_q;
		shown_d = shown_q;
		cd_dec  = (cd_q != '0) ? cd_q - 16'd1 : '0;
		diff    = min_s2 - shown_q;
		sum     = {1'b0, pend_q} + {1'b0, cnt_s2};

		unique case (op_s2)
			OP_TICK: begin
				// running pulse advances first
				unique case (phase_q)
					PH_HIGH: begin
						if (cd_dec == '0) begin
							if (gap_q == '0) begin
								pol_d   = ~pol_q;
								phase_d = PH_IDLE;
								cd_d    = '0;
							end else begin
								phase_d = PH_LOW;
								cd_d    = gap_q;
							end
						end else begin
							cd_d = cd_dec;
						end
					end
					PH_LOW: begin
						if (cd_dec == '0) begin
							pol_d   = ~pol_q;
							phase_d = PH_IDLE;
							cd_d    = '0;
						end else begin
							cd_d = cd_dec;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
				if (phase_d == PH_IDLE) begin
					// minute catch-up only with an empty queue
					if (pend_q == '0 && ge_s2 && shown_q < min_s2) begin
						pend_d  = (|diff[MIN_W-1:CNT_W]) ? CNT_MAX : diff[CNT_W-1:0];
						shown_d = min_s2;
					end
					// start a queued pulse with enable already high
					if (pend_d != '0) begin
						pend_d  = pend_d - 16'd1;
						phase_d = PH_HIGH;
						cd_d    = (width_q != '0) ? width_q : 16'd1;
					end
				end
			end
			OP_SET_TIME:   shown_d = min_s2;
			OP_ADD_PULSES: pend_d = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q   <= 1'b0;
			pend_q  <= PENDING_RESET;
			phase_q <= PH_IDLE;
			cd_q    <= '0;
			shown_q <= '0;
		end else if (adv3) begin
			pol_q   <= pol_d;
			pend_q  <= pend_d;
			phase_q <= phase_d;
			cd_q    <= cd_d;
			shown_q <= shown_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv3) begin
			res.enable_level   <= phase_d == PH_HIGH;
			res.bridge_a_level <= pol_d;
			res.bridge_b_level <= ~pol_d;
			res.busy_res       <= (phase_d != PH_IDLE) || (pend_d != '0);
			res.pulses_left    <= pend_d;
		end
	end

	assign res.valid = outv_q;

	// A pulse in progress always has ticks left; idle keeps the count clear
	a_phase_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) ? (cd_q == '0) : (cd_q != '0))
		else $error("phase and countdown disagree");

	// Driver state moves only when a word enters the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv3 |=> $stable(pend_q) && $stable(phase_q) && $stable(pol_q))
		else $error("state changed without a word");

	// A stalled result keeps the word behind it in stage 2
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && !res.ready && s2v_q) |=> s2v_q)
		else $error("stage 2 word lost under stall");

	// Busy low in a result means no pulse and an empty queue
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && !res.busy_res) |-> (res.pulses_left == '0 && !res.enable_level))
		else $error("idle result with pulse activity");
endmodule

// ===== rtl/core/mcpd_div60.sv =====
// Two-stage floor division of epoch seconds by 60, giving epoch minutes.
module mcpd_div60 (
	input  logic                           clk,
	input  mcpd_pkg::pipe_en_t             en,
	input  logic [mcpd_pkg::TIME_W-1:0]    seconds,
	output logic [mcpd_pkg::MIN_W-1:0]     minutes_s2
);
	import mcpd_pkg::*;

	logic [QUART_W-1:0] quarter_s1;
	logic [PROD_W-1:0]  prod;

	// Stage 1: divide by 4
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			quarter_s1 <= seconds[TIME_W-1:2];
		end
	end

	// Divide by 15 through the reciprocal, exact over the full range
	assign prod = {{QUART_W{1'b0}}, quarter_s1} * {{QUART_W{1'b0}}, RECIP_15};

	// Stage 2: registered quotient
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			minutes_s2 <= prod[RECIP_SHIFT +: MIN_W];
		end
	end
endmodule

// ===== tb/sv/mcpd_drive_checker.sv =====
`timescale 1ns / 1ps
// Checker for the pulse driver: watches both channels and the register port, predicts and compares.
module mcpd_drive_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	mcpd_cmd_if                        cmd,
	mcpd_res_if                        res,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [mcpd_pkg::CNT_W-1:0] wr_data,
	output int                         fail_count,
	output int                         waiting
);
	import mcpd_pkg::*;

	localparam logic [TIME_W-1:0] SEC_PER_MIN = 34'd60;

	typedef struct packed {
		logic             enable;
		logic             bridge_a;
		logic             bridge_b;
		logic             busy;
		logic [CNT_W-1:0] left;
	} drive_word_t;

	// Predicted driver state and register copies
	logic [CNT_W-1:0]  width_reg;
	logic [CNT_W-1:0]  gap_reg;
	logic              polarity;
	logic [CNT_W-1:0]  queued;
	phase_t            phase;
	logic [CNT_W-1:0]  countdown;
	logic [TIME_W-1:0] shown;

	drive_word_t expected_drive[$];

	// End of the low phase, or of the high phase with a zero gap: flip the bridge and go idle
	function automatic void close_gap();
		polarity  = ~polarity;
		phase     = PH_IDLE;
		countdown = '0;
	endfunction

	// Apply one command word and return the levels that follow it
	function automatic drive_word_t predict_drive(logic [OP_W-1:0] op,
			logic [TIME_W-1:0] now, logic [TIME_W-1:0] val);
		logic [TIME_W-1:0] floored;
		logic [TIME_W-1:0] minutes;
		logic [CNT_W-1:0]  cnt;
		logic [CNT_W:0]    sum;
		drive_word_t       w;
		case (op)
			OP_TICK: begin
				// a running pulse moves on first
				if (phase == PH_HIGH) begin
					if (countdown != 0) countdown--;
					if (countdown == 0) begin
						phase     = PH_LOW;
						countdown = gap_reg;
						if (countdown == 0) close_gap();
					end
				end else if (phase == PH_LOW) begin
					if (countdown != 0) countdown--;
					if (countdown == 0) close_gap();
				end
				if (phase == PH_IDLE) begin
					// minute catch-up only with an empty queue and a valid wall time
					if (queued == 0 && now >= VALID_FLOOR) begin
						floored = (now / SEC_PER_MIN) * SEC_PER_MIN;
						if (shown < floored) begin
							minutes = (floored - shown) / SEC_PER_MIN;
							queued  = (minutes > CNT_MAX) ? CNT_MAX : minutes[CNT_W-1:0];
							shown   = floored;
						end
					end
					if (queued != 0) begin
						queued--;
						phase     = PH_HIGH;
						countdown = (width_reg != 0) ? width_reg : CNT_W'(1);
					end
				end
			end
			OP_SET_TIME: begin
				shown = (val / SEC_PER_MIN) * SEC_PER_MIN;
			end
			OP_ADD_PULSES: begin
				cnt    = (val > CNT_MAX) ? CNT_MAX : val[CNT_W-1:0];
				sum    = {1'b0, queued} + {1'b0, cnt};
				queued = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
			end
			default: ;
		endcase
		w.enable   = (phase == PH_HIGH);
		w.bridge_a = polarity;
		w.bridge_b = ~polarity;
		w.busy     = (phase != PH_IDLE) || (queued != 0);
		w.left     = queued;
		return w;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Sample at the rising edge: apply register writes, retire results, then predict the new word
	always @(posedge clk or negedge arst_n) begin : watch
		drive_word_t want;
		if (!arst_n) begin
			width_reg  = PULSE_WIDTH_RESET;
			gap_reg    = PULSE_GAP_RESET;
			polarity   = 1'b0;
			queued     = PENDING_RESET;
			phase      = PH_IDLE;
			countdown  = '0;
			shown      = '0;
			fail_count = 0;
			expected_drive.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == REG_PULSE_WIDTH) width_reg = wr_data;
				else gap_reg = wr_data;
			end
			if (res.valid && res.ready) begin
				if (expected_drive.size() == 0) begin
					$error("result word arrived with nothing expected");
					fail_count++;
				end else begin
					want = expected_drive.pop_front();
					compare_field("enable_level", 32'(want.enable), 32'(res.enable_level));
					compare_field("bridge_a_level", 32'(want.bridge_a),
						32'(res.bridge_a_level));
					compare_field("bridge_b_level", 32'(want.bridge_b),
						32'(res.bridge_b_level));
					compare_field("busy_res", 32'(want.busy), 32'(res.busy_res));
					compare_field("pulses_left", 32'(want.left), 32'(res.pulses_left));
				end
			end
			if (cmd.valid && cmd.ready)
				expected_drive.push_back(predict_drive(cmd.operation, cmd.now_seconds,
					cmd.operand_value));
		end
		waiting = expected_drive.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, command and register stimulus, result back-pressure and verdict.
module tb_top;
	import mcpd_pkg::*;

	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam logic [TIME_W-1:0] WALL_CEIL   = 34'h3_FFFF_0000;
	localparam logic [TIME_W-1:0] SEC_PER_MIN = 34'd60;
	localparam int                PHASE_WORDS = 430;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             wr_en;
	logic             wr_index;
	logic [CNT_W-1:0] wr_data;
	logic             last_busy = 1'b1;
	int               send_idle;
	int               recv_idle;
	int               hold_cycles;
	int               fail_count;
	int               waiting;
	logic [TIME_W-1:0] wall;

	mcpd_cmd_if cmd ();
	mcpd_res_if res ();

	minute_catchup_polarity_pulse_driver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	mcpd_drive_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res        (res),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	always #5 clk = ~clk;

	// Busy flag of the latest result word, used to wait for an empty queue
	always @(posedge clk) begin
		if (res.valid && res.ready) last_busy <= res.busy_res;
	end

	// Receiver: random back-pressure, plus long hold-offs on request
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	function automatic logic [TIME_W-1:0] any_time();
		return {2'($urandom_range(0, 3)), 32'($urandom())};
	endfunction

	// Offer one word after a random gap; returns at the falling edge after acceptance
	task automatic send_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.operation     <= op;
		cmd.now_seconds   <= now;
		cmd.operand_value <= val;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
	endtask

	task automatic tick(input logic [TIME_W-1:0] now);
		send_word(OP_TICK, now, any_time());
	endtask

	// Stop offering and let every outstanding result come back
	task automatic drain();
		cmd.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [CNT_W-1:0] width, input logic [CNT_W-1:0] gap);
		wr_en    <= 1'b1;
		wr_index <= REG_PULSE_WIDTH;
		wr_data  <= width;
		@(negedge clk);
		wr_index <= REG_PULSE_GAP;
		wr_data  <= gap;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	// Mostly set-time then a run of ticks near the wall time; the rest is noise
	task automatic run_mix(input int words);
		int               sent;
		logic [TIME_W-1:0] shown_val;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(0, 99) < 75) begin
				if (wall > WALL_CEIL || $urandom_range(0, 3) == 0) begin
					wall = any_time();
					if (wall < VALID_FLOOR) wall = wall + VALID_FLOOR;
					if (wall > WALL_CEIL) wall = wall - 34'h1_0000;
				end
				// display a few minutes behind, now and then ahead
				if ($urandom_range(0, 5) == 0)
					shown_val = wall + TIME_W'($urandom_range(60, 600));
				else
					shown_val = wall - SEC_PER_MIN * TIME_W'($urandom_range(0, 4))
						- TIME_W'($urandom_range(0, 59));
				send_word(OP_SET_TIME, any_time(), shown_val);
				sent++;
				repeat ($urandom_range(4, 30)) begin
					if ($urandom_range(0, 9) == 0) wall = wall + TIME_W'($urandom_range(1, 90));
					if ($urandom_range(0, 11) == 0)
						send_word(OP_ADD_PULSES, any_time(), TIME_W'($urandom_range(0, 3)));
					else
						tick(wall);
					sent++;
				end
			end else begin
				// noise ticks stay below the floor so no runaway catch-up
				case ($urandom_range(0, 3))
					0: tick(TIME_W'($urandom_range(0, 32'(VALID_FLOOR - 1))));
					1: send_word(OP_SET_TIME, any_time(), any_time());
					2: send_word(OP_ADD_PULSES, any_time(), TIME_W'($urandom_range(0, 3)));
					default: begin
						send_word(OP_UNUSED, any_time(), any_time());
						sent--;
					end
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.operation     = OP_TICK;
		cmd.now_seconds   = '0;
		cmd.operand_value = '0;
		wr_en             = 1'b0;
		wr_index          = REG_PULSE_WIDTH;
		wr_data           = '0;
		send_idle         = 0;
		recv_idle         = 0;
		hold_cycles       = 0;
		wall              = VALID_FLOOR;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero width and zero gap, two pulses queued from reset
		set_config('0, '0);
		send_word(OP_UNUSED, TIME_MAX, TIME_MAX);
		tick('0);
		tick('0);
		send_word(OP_ADD_PULSES, TIME_MAX, '0);
		send_word(OP_SET_TIME, '0, TIME_MAX);
		tick(TIME_MAX);
		send_word(OP_SET_TIME, '0, VALID_FLOOR - 34'd167);
		tick(VALID_FLOOR - 34'd1);
		repeat (4) tick(VALID_FLOOR + 34'd59);
		send_word(OP_ADD_PULSES, '0, 34'd2);
		repeat (4) tick(VALID_FLOOR + 34'd119);
		send_word(OP_ADD_PULSES, '0, 34'd1);
		repeat (2) tick(VALID_FLOOR + 34'd59);
		drain();

		// Random: sender gaps light, receiver stalls heavy
		send_idle = 31;
		recv_idle = 55;
		set_config(16'd3, 16'd2);
		run_mix(PHASE_WORDS);
		drain();

		// Random: the other way round
		send_idle = 55;
		recv_idle = 31;
		set_config(16'd1, 16'd0);
		run_mix(PHASE_WORDS);
		drain();

		// Random: full rate, with one long receiver hold-off to fill the pipe
		send_idle = 0;
		recv_idle = 0;
		set_config(16'd5, 16'd3);
		run_mix(150);
		hold_cycles = 80;
		run_mix(PHASE_WORDS - 150);
		drain();

		// Saturation last, as the queue never empties afterwards: first run it dry
		set_config(16'd1, 16'd0);
		send_word(OP_SET_TIME, any_time(), TIME_MAX);
		do begin
			repeat (16) tick(VALID_FLOOR);
			drain();
		end while (last_busy);
		set_config(CNT_MAX, CNT_MAX);
		send_word(OP_SET_TIME, any_time(), VALID_FLOOR - SEC_PER_MIN * 34'd70000);
		tick(VALID_FLOOR + 34'd30);
		send_word(OP_ADD_PULSES, any_time(), TIME_MAX);
		send_word(OP_ADD_PULSES, any_time(), 34'd70000);
		repeat (4) tick(TIME_MAX);
		drain();

		if (fail_count == 0 && waiting == 0) begin
			$display("PASS minute_catchup_polarity_pulse_driver");
		end else begin
			$display("FAIL minute_catchup_polarity_pulse_driver");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL minute_catchup_polarity_pulse_driver");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mcpd_pkg.sv
rtl/core/mcpd_cmd_if.sv
rtl/core/mcpd_res_if.sv
rtl/core/mcpd_div60.sv
rtl/core/minute_catchup_polarity_pulse_driver.sv
tb/sv/mcpd_drive_checker.sv
tb/sv/tb_top.sv
